[rtl/ita_pkg.sv]
// ita_pkg: shared widths, codes, state type and digit-to-ascii function
// for the integer to ascii converter. No dependencies.
// Used by ita_dabble and integer_to_ascii_radix.
package ita_pkg;

   // operand widths
   localparam int VALUE_WIDTH   = 64;
   localparam int NARROW_WIDTH  = 32;

   // the shift-and-adjust unit takes this many operand bits per cycle
   localparam int STEP_BITS     = 4;
   localparam int OP_STEPS      = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int NARROW_STEPS  = NARROW_WIDTH / STEP_BITS;
   localparam int OP_WIDTH      = OP_STEPS * STEP_BITS;

   // digit counts per radix
   localparam int DEC_DIGITS    = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int OCT_DIGITS    = (VALUE_WIDTH + 2) / 3;
   localparam int OCT_PAD_WIDTH = OCT_DIGITS * 3;
   localparam int NUM_DIGITS    = OCT_DIGITS;
   localparam int DIGIT_REG_WIDTH = NUM_DIGITS * 4;

   localparam int COUNT_WIDTH    = $clog2(NUM_DIGITS + 1);
   localparam int STEP_CNT_WIDTH = $clog2(OP_STEPS + 1);

   // radix codes
   typedef logic [1:0] radix_type;
   localparam radix_type RADIX_DEC = 2'd0;
   localparam radix_type RADIX_HEX = 2'd1;
   localparam radix_type RADIX_OCT = 2'd2;

   // ascii constants
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_LETTER_A = 8'h41;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // one digit value to its upper-case ascii character
   function automatic logic [7:0] digit_char(input logic [3:0] digit);
      logic [7:0] result;
      if (digit < 4'd10) begin
         result = CHAR_ZERO + {4'b0000, digit};
      end else begin
         result = CHAR_LETTER_A + {4'b0000, digit} - 8'd10;
      end
      return result;
   endfunction

endpackage

[rtl/ita_dabble.sv]
// ita_dabble: shift-and-add-3 unit, moves STEP_BITS operand bits into the
// bcd digit register per pass. Depends on ita_pkg.
module ita_dabble
   import ita_pkg::*;
(
   input  logic [DIGIT_REG_WIDTH-1:0] digits_in,
   input  logic [OP_WIDTH-1:0]        op_in,
   output logic [DIGIT_REG_WIDTH-1:0] digits_out,
   output logic [OP_WIDTH-1:0]        op_out
);

   logic [DIGIT_REG_WIDTH-1:0] dig;
   logic [OP_WIDTH-1:0]        op;

   // per bit: adjust every decimal digit of five or more, then shift one bit in
   always_comb begin
      dig = digits_in;
      op  = op_in;
      for (int s = 0; s < STEP_BITS; s++) begin
         for (int d = 0; d < DEC_DIGITS; d++) begin
            if (dig[d*4 +: 4] >= 4'd5) begin
               dig[d*4 +: 4] = dig[d*4 +: 4] + 4'd3;
            end
         end
         dig = {dig[DIGIT_REG_WIDTH-2:0], op[OP_WIDTH-1]};
         op  = {op[OP_WIDTH-2:0], 1'b0};
      end
      digits_out = dig;
      op_out     = op;
   end

endmodule

[rtl/integer_to_ascii_radix.sv]
// Integer to ascii text converter, decimal, upper-case hexadecimal or octal,
// one character word out per handshake, most significant digit first, with
// rsp_last on the final character. Uses ita_pkg and ita_dabble.
//
// One number at a time: req_stall stays high from acceptance until the last
// character has been loaded into the output register. Decimal runs the
// shared shift-and-add-3 unit four operand bits per cycle over a 32-bit or
// 64-bit operand; hexadecimal and octal load their digits directly. The digit
// register then drops one leading zero digit per cycle and then emits one
// character per cycle while the result side takes them, after a minus sign
// for a negative number.
module integer_to_ascii_radix
   import ita_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   req_wide,
   input  logic [1:0]             req_radix_select,
   input  logic                   req_is_signed,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_character,
   output logic                   rsp_last
);

   state_type                  state_ff, state_in;
   logic [DIGIT_REG_WIDTH-1:0] digits_ff, digits_in;
   logic [OP_WIDTH-1:0]        op_ff, op_in;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [STEP_CNT_WIDTH-1:0]  step_ff, step_in;
   logic                       negative_ff, negative_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_character_ff, rsp_character_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [DIGIT_REG_WIDTH-1:0] dabble_digits;
   logic [OP_WIDTH-1:0]        dabble_op;

   logic                       accept;
   logic                       out_free;
   logic                       is_dec;
   logic                       is_hex;
   logic                       sign_bit;
   logic                       negative;
   logic [VALUE_WIDTH-1:0]     mag_raw;
   logic [VALUE_WIDTH-1:0]     neg_full;
   logic [VALUE_WIDTH-1:0]     mag;
   logic [OCT_PAD_WIDTH-1:0]   oct_pad;
   logic [DIGIT_REG_WIDTH-1:0] oct_digits;
   logic [3:0]                 top_digit;

   // shared decimal conversion unit
   ita_dabble u_dabble (
      .digits_in  (digits_ff),
      .op_in      (op_ff),
      .digits_out (dabble_digits),
      .op_out     (dabble_op)
   );

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign top_digit = digits_ff[DIGIT_REG_WIDTH-1 -: 4];

   // radix decode, unused code converts as decimal
   always_comb begin
      case (req_radix_select)
         RADIX_HEX: begin
            is_dec = 1'b0;
            is_hex = 1'b1;
         end
         RADIX_OCT: begin
            is_dec = 1'b0;
            is_hex = 1'b0;
         end
         default: begin
            is_dec = 1'b1;
            is_hex = 1'b0;
         end
      endcase
   end

   // operand selection and signed magnitude
   always_comb begin
      mag_raw  = req_wide ? req_value
                          : VALUE_WIDTH'(req_value[NARROW_WIDTH-1:0]);
      sign_bit = req_wide ? req_value[VALUE_WIDTH-1] : req_value[NARROW_WIDTH-1];
      negative = req_is_signed && is_dec && sign_bit;
      neg_full = ~mag_raw + 1'b1;
      if (negative) begin
         mag = req_wide ? neg_full : VALUE_WIDTH'(neg_full[NARROW_WIDTH-1:0]);
      end else begin
         mag = mag_raw;
      end
   end

   // octal digits spread one per nibble
   always_comb begin
      oct_pad    = OCT_PAD_WIDTH'(mag);
      oct_digits = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         oct_digits[i*4 +: 4] = {1'b0, oct_pad[i*3 +: 3]};
      end
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      digits_in        = digits_ff;
      op_in            = op_ff;
      count_in         = count_ff;
      step_in          = step_ff;
      negative_in      = negative_ff;
      rsp_valid_in     = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      req_stall        = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               negative_in = negative;
               count_in    = COUNT_WIDTH'(NUM_DIGITS);
               if (is_dec) begin
                  digits_in = '0;
                  if (req_wide) begin
                     op_in   = OP_WIDTH'(mag);
                     step_in = STEP_CNT_WIDTH'(OP_STEPS);
                  end else begin
                     op_in   = OP_WIDTH'(mag[NARROW_WIDTH-1:0]) << (OP_WIDTH - NARROW_WIDTH);
                     step_in = STEP_CNT_WIDTH'(NARROW_STEPS);
                  end
                  state_in = ST_CONVERT;
               end else begin
                  digits_in = is_hex ? DIGIT_REG_WIDTH'(mag) : oct_digits;
                  state_in  = ST_SKIP;
               end
            end
         end
         ST_CONVERT: begin
            digits_in = dabble_digits;
            op_in     = dabble_op;
            step_in   = step_ff - 1'b1;
            if (step_ff == STEP_CNT_WIDTH'(1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top_digit == 4'd0 && count_ff > COUNT_WIDTH'(1)) begin
               digits_in = digits_ff << 4;
               count_in  = count_ff - 1'b1;
            end else begin
               state_in = negative_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = CHAR_MINUS;
               rsp_last_in      = 1'b0;
               state_in         = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = digit_char(top_digit);
               rsp_last_in      = (count_ff == COUNT_WIDTH'(1));
               digits_in        = digits_ff << 4;
               count_in         = count_ff - 1'b1;
               if (count_ff == COUNT_WIDTH'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      digits_ff        <= digits_in;
      op_ff            <= op_in;
      count_ff         <= count_in;
      step_ff          <= step_in;
      negative_ff      <= negative_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

[test/integer_to_ascii_radix_test.sv]
`timescale 1ns / 1ps
// integer_to_ascii_radix_test: self-checking bench for the integer to ascii
// converter, with its own text predictor and randomised idling on both sides.
// Depends on ita_pkg and the integer_to_ascii_radix rtl.
module integer_to_ascii_radix_test
   import ita_pkg::*;
();

   localparam radix_type RADIX_SPARE    = 2'd3;
   localparam logic      NARROW         = 1'b0;
   localparam logic      WIDE           = 1'b1;
   localparam logic      AS_UNSIGNED    = 1'b0;
   localparam logic      AS_SIGNED      = 1'b1;
   localparam int        WATCHDOG_LIMIT = 2000;
   localparam int        SETTLE_CYCLES  = 48;

   typedef struct packed {
      logic [7:0] ascii;
      logic       last;
   } text_char_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [VALUE_WIDTH-1:0] req_value = '0;
   logic                   req_wide = 1'b0;
   logic [1:0]             req_radix_select = RADIX_DEC;
   logic                   req_is_signed = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_character;
   logic                   rsp_last;

   text_char_type pending_text[$];
   int            send_idle_pct = 0;
   int            rsp_idle_pct = 0;
   int            failures = 0;
   int            quiet_cycles = 0;

   integer_to_ascii_radix dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_wide         (req_wide),
      .req_radix_select (req_radix_select),
      .req_is_signed    (req_is_signed),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // expected text of one number, queued most significant digit first
   function automatic void predict_text(input logic [63:0] value, input logic wide,
                                        input logic [1:0] radix, input logic is_signed);
      string         digit_set;
      logic [63:0]   mask;
      logic [63:0]   mag;
      logic [63:0]   base;
      logic          negative;
      byte           digits[$];
      text_char_type entry;
      digit_set = "0123456789ABCDEF";
      mask = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
      mag = value & mask;
      case (radix)
         RADIX_HEX: base = 64'd16;
         RADIX_OCT: base = 64'd8;
         default:   base = 64'd10;
      endcase
      // sign only honoured for decimal
      negative = is_signed && (base == 64'd10) && (wide ? mag[63] : mag[31]);
      if (negative) begin
         mag = (~mag + 64'd1) & mask;
      end
      if (mag == 64'd0) begin
         digits.push_front(CHAR_ZERO);
      end
      while (mag != 64'd0) begin
         digits.push_front(digit_set[int'(mag % base)]);
         mag = mag / base;
      end
      if (negative) begin
         digits.push_front(CHAR_MINUS);
      end
      foreach (digits[i]) begin
         entry.ascii = digits[i];
         entry.last  = (i == digits.size() - 1);
         pending_text.push_back(entry);
      end
   endfunction

   // receiver stall pattern
   always @(negedge clock) begin
      rsp_stall <= (rsp_idle_pct != 0) && ($urandom_range(99) < rsp_idle_pct);
   end

   // compare each accepted character word with the oldest expectation
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_text.size() == 0) begin
            $error("unexpected word: character %h last %b", rsp_character, rsp_last);
            failures = failures + 1;
         end else begin
            want = pending_text.pop_front();
            if (rsp_character !== want.ascii) begin
               $error("character mismatch: expected %h, actual %h", want.ascii, rsp_character);
               failures = failures + 1;
            end
            if (rsp_last !== want.last) begin
               $error("last mismatch: expected %b, actual %b", want.last, rsp_last);
               failures = failures + 1;
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("integer_to_ascii_radix_test failed");
         $finish;
      end
   end

   // offer one request word, with an optional gap first, and wait for acceptance
   task automatic send_word(input logic [63:0] value, input logic wide,
                            input logic [1:0] radix, input logic is_signed);
      int gap;
      gap = 0;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 4);
      end
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_value        <= value;
      req_wide         <= wide;
      req_radix_select <= radix;
      req_is_signed    <= is_signed;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      predict_text(value, wide, radix, is_signed);
   endtask

   // sender holds off until every expected character has arrived
   task automatic wait_text_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
   endtask

   // zeros, widest numbers, most negative values and the odd codes
   task automatic test_directed_extremes();
      send_word(64'd0, NARROW, RADIX_DEC, AS_UNSIGNED);
      send_word(64'd0, WIDE, RADIX_HEX, AS_UNSIGNED);
      send_word(64'd0, WIDE, RADIX_OCT, AS_SIGNED);
      send_word(64'd0, NARROW, RADIX_DEC, AS_SIGNED);
      send_word(64'h0000_0000_FFFF_FFFF, NARROW, RADIX_DEC, AS_UNSIGNED);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, WIDE, RADIX_DEC, AS_UNSIGNED);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, WIDE, RADIX_HEX, AS_UNSIGNED);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, WIDE, RADIX_OCT, AS_UNSIGNED);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, NARROW, RADIX_OCT, AS_UNSIGNED);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, NARROW, RADIX_HEX, AS_UNSIGNED);
      send_word(64'h0000_0000_8000_0000, NARROW, RADIX_DEC, AS_SIGNED);
      send_word(64'h8000_0000_0000_0000, WIDE, RADIX_DEC, AS_SIGNED);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, WIDE, RADIX_DEC, AS_SIGNED);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, NARROW, RADIX_DEC, AS_SIGNED);
      send_word(64'h7FFF_FFFF_FFFF_FFFF, WIDE, RADIX_DEC, AS_SIGNED);
      send_word(64'h0000_0000_7FFF_FFFF, NARROW, RADIX_DEC, AS_SIGNED);
      // bits above a narrow operand are ignored
      send_word(64'hFFFF_FFFF_0000_0000, NARROW, RADIX_DEC, AS_UNSIGNED);
      send_word(64'h1234_5678_8000_0001, NARROW, RADIX_DEC, AS_SIGNED);
      // sign ignored outside decimal
      send_word(64'h8000_0000_0000_0000, WIDE, RADIX_HEX, AS_SIGNED);
      send_word(64'hFFFF_FFFF_FFFF_FFF8, WIDE, RADIX_OCT, AS_SIGNED);
      // spare radix code behaves as decimal
      send_word(64'hFFFF_FFFF_FFFF_FF85, WIDE, RADIX_SPARE, AS_SIGNED);
      send_word(64'd1234567890, NARROW, RADIX_SPARE, AS_UNSIGNED);
      send_word(64'h0123_4567_89AB_CDEF, WIDE, RADIX_HEX, AS_UNSIGNED);
      send_word(64'd9, NARROW, RADIX_OCT, AS_UNSIGNED);
   endtask

   // random requests with a mix of operand shapes
   task automatic test_random_words(input int count);
      logic [63:0] raw;
      logic [63:0] value;
      logic [63:0] power;
      for (int n = 0; n < count; n++) begin
         raw = {$urandom, $urandom};
         case ($urandom_range(0, 5))
            0, 1: value = raw;
            // short numbers
            2: value = raw >> $urandom_range(0, 63);
            // small negatives in either width
            3: value = ~(raw >> $urandom_range(0, 63));
            // power of two boundaries
            4: value = (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
            // decimal digit count boundaries
            default: begin
               power = 64'd1;
               repeat ($urandom_range(0, 19)) power = power * 64'd10;
               value = power - 64'($urandom_range(0, 1));
            end
         endcase
         if (n == count / 2) begin
            wait_text_drained();
         end
         send_word(value, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 9;
      rsp_idle_pct  = 82;
      test_directed_extremes();
      test_random_words(150);

      send_idle_pct = 82;
      rsp_idle_pct  = 9;
      test_random_words(150);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_words(150);

      // drain and let the converter settle
      wait_text_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("integer_to_ascii_radix_test passed");
      end else begin
         $display("integer_to_ascii_radix_test failed");
      end
      $finish;
   end

endmodule
